// ===== src/pps_pkg.sv =====
// Shared field widths and controller/datapath command and status types for the scheduler.
`timescale 1ns / 1ps

package pps_pkg;

    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int PIDX_W = 4;
    localparam int OUT_W  = 21;
    localparam int ST_W   = ARR_W + BUR_W + PRI_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_wr;
        logic scan_init;
        logic scan_rd;
        logic decide;
        logic emit_rd;
        logic emit_cap;
        logic set_clear;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic sched_done;
        logic out_last;
    } sts_t;

endpackage

// ===== src/pps_in_if.sv =====
// Input channel: one process description per transfer.
`timescale 1ns / 1ps

interface pps_in_if;

    logic                       valid;
    logic                       ready;
    logic [pps_pkg::ARR_W-1:0]  arrival_time;
    logic [pps_pkg::BUR_W-1:0]  burst_time;
    logic [pps_pkg::PRI_W-1:0]  priority_req;
    logic                       last_process;

    modport source (
        output valid,
        output arrival_time,
        output burst_time,
        output priority_req,
        output last_process,
        input  ready
    );

    modport sink (
        input  valid,
        input  arrival_time,
        input  burst_time,
        input  priority_req,
        input  last_process,
        output ready
    );

endinterface

// ===== src/pps_out_if.sv =====
// Output channel: one scheduling result per transfer.
`timescale 1ns / 1ps

interface pps_out_if;

    logic                        valid;
    logic                        ready;
    logic [pps_pkg::PIDX_W-1:0]  process_index;
    logic [pps_pkg::OUT_W-1:0]   finish_time;
    logic [pps_pkg::OUT_W-1:0]   turnaround_time;
    logic [pps_pkg::OUT_W-1:0]   waiting_time;
    logic                        last_result;

    modport source (
        output valid,
        output process_index,
        output finish_time,
        output turnaround_time,
        output waiting_time,
        output last_result,
        input  ready
    );

    modport sink (
        input  valid,
        input  process_index,
        input  finish_time,
        input  turnaround_time,
        input  waiting_time,
        input  last_result,
        output ready
    );

endinterface

// ===== src/pps_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pps_datapath.sv =====
// Scheduler datapath: process stores, tick counter, priority scan and result arithmetic.
`timescale 1ns / 1ps

module pps_datapath #(
    parameter int MAX_PROCS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pps_pkg::cmd_t              cmd,
    output pps_pkg::sts_t              sts,
    input  logic [pps_pkg::ARR_W-1:0]  arrival_time,
    input  logic [pps_pkg::BUR_W-1:0]  burst_time,
    input  logic [pps_pkg::PRI_W-1:0]  priority_req,
    output logic [pps_pkg::PIDX_W-1:0] process_index,
    output logic [pps_pkg::OUT_W-1:0]  finish_time,
    output logic [pps_pkg::OUT_W-1:0]  turnaround_time,
    output logic [pps_pkg::OUT_W-1:0]  waiting_time,
    output logic                       last_result
);

    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int TICK_W = pps_pkg::ARR_W + CNT_W;
    localparam int ARR_W  = pps_pkg::ARR_W;
    localparam int BUR_W  = pps_pkg::BUR_W;
    localparam int PRI_W  = pps_pkg::PRI_W;
    localparam int OUT_W  = pps_pkg::OUT_W;
    localparam int ST_W   = pps_pkg::ST_W;

    // Control state
    logic [CNT_W-1:0]  loaded_count_reg, loaded_count_next;
    logic [CNT_W-1:0]  finished_count_reg, finished_count_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              found_reg, found_next;
    logic              rd_valid_reg;

    // Scan and result payload
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic [PRI_W-1:0]  best_pri_reg, best_pri_next;
    logic [BUR_W-1:0]  best_rem_reg, best_rem_next;
    logic [ARR_W-1:0]  next_arr_reg, next_arr_next;
    logic [pps_pkg::PIDX_W-1:0] process_index_reg;
    logic [OUT_W-1:0]  finish_time_reg;
    logic [OUT_W-1:0]  turnaround_time_reg;
    logic [OUT_W-1:0]  waiting_time_reg;
    logic              last_result_reg;

    // Memory ports
    logic              st_we;
    logic [ST_W-1:0]   st_wdata, st_rdata;
    logic              rem_we;
    logic [IDX_W-1:0]  rem_waddr;
    logic [BUR_W-1:0]  rem_wdata, rem_rdata;
    logic              fin_we;
    logic [TICK_W-1:0] fin_wdata, fin_rdata;

    logic              full;
    logic [BUR_W-1:0]  burst_fixed;
    logic [ARR_W-1:0]  entry_arr;
    logic [BUR_W-1:0]  entry_bur;
    logic [PRI_W-1:0]  entry_pri;
    logic              entry_arrived;
    logic              pick_finishes;
    logic [TICK_W-1:0] tat_full, wt_full;

    assign full          = (loaded_count_reg == CNT_W'(MAX_PROCS));
    assign burst_fixed   = (burst_time == '0) ? BUR_W'(1) : burst_time;
    assign entry_arr     = st_rdata[ST_W-1 -: ARR_W];
    assign entry_bur     = st_rdata[PRI_W +: BUR_W];
    assign entry_pri     = st_rdata[PRI_W-1:0];
    assign entry_arrived = (TICK_W'(entry_arr) <= tick_reg);
    assign pick_finishes = found_reg && (best_rem_reg == BUR_W'(1));

    assign st_we    = cmd.load_wr && !full;
    assign st_wdata = {arrival_time, burst_fixed, priority_req};

    assign rem_we    = (cmd.load_wr && !full) || (cmd.decide && found_reg);
    assign rem_waddr = cmd.load_wr ? loaded_count_reg[IDX_W-1:0] : pick_reg;
    assign rem_wdata = cmd.load_wr ? burst_fixed : best_rem_reg - BUR_W'(1);

    assign fin_we    = cmd.decide && pick_finishes;
    assign fin_wdata = tick_reg + TICK_W'(1);

    pps_ram #(.WIDTH(ST_W), .DEPTH(MAX_PROCS)) u_static_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (loaded_count_reg[IDX_W-1:0]),
        .wdata (st_wdata),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (st_rdata)
    );

    pps_ram #(.WIDTH(BUR_W), .DEPTH(MAX_PROCS)) u_remaining_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (rem_rdata)
    );

    pps_ram #(.WIDTH(TICK_W), .DEPTH(MAX_PROCS)) u_finish_ram (
        .clk   (clk),
        .we    (fin_we),
        .waddr (pick_reg),
        .wdata (fin_wdata),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (fin_rdata)
    );

    // Counters and tick
    always_comb
    begin
        loaded_count_next   = loaded_count_reg;
        finished_count_next = finished_count_reg;
        tick_next           = tick_reg;
        ptr_next            = ptr_reg;

        if (cmd.set_clear)
        begin
            loaded_count_next = '0;
        end
        else if (cmd.load_wr && !full)
        begin
            loaded_count_next = loaded_count_reg + CNT_W'(1);
        end

        if (cmd.scan_init)
        begin
            finished_count_next = '0;
            tick_next           = '0;
            ptr_next            = '0;
        end
        else if (cmd.decide)
        begin
            if (found_reg)
            begin
                tick_next = tick_reg + TICK_W'(1);
            end
            else
            begin
                tick_next = TICK_W'(next_arr_reg);
            end
            if (pick_finishes)
            begin
                finished_count_next = finished_count_reg + CNT_W'(1);
            end
        end
        else if (cmd.scan_rd)
        begin
            ptr_next = sts.scan_last ? '0 : ptr_reg + CNT_W'(1);
        end
        else if (cmd.emit_rd)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    // Priority scan over the entries read back one per cycle
    always_comb
    begin
        found_next    = found_reg;
        pick_next     = pick_reg;
        best_pri_next = best_pri_reg;
        best_rem_next = best_rem_reg;
        next_arr_next = next_arr_reg;

        if (cmd.scan_init || cmd.decide)
        begin
            found_next    = 1'b0;
            next_arr_next = '1;
        end
        else if (rd_valid_reg && (rem_rdata != '0))
        begin
            if (entry_arrived)
            begin
                if (!found_reg || (entry_pri > best_pri_reg))
                begin
                    found_next    = 1'b1;
                    pick_next     = rd_idx_reg;
                    best_pri_next = entry_pri;
                    best_rem_next = rem_rdata;
                end
            end
            else if (entry_arr < next_arr_reg)
            begin
                next_arr_next = entry_arr;
            end
        end
    end

    assign tat_full = fin_rdata - TICK_W'(entry_arr);
    assign wt_full  = tat_full - TICK_W'(entry_bur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_count_reg   <= '0;
            finished_count_reg <= '0;
            tick_reg           <= '0;
            ptr_reg            <= '0;
            found_reg          <= 1'b0;
            rd_valid_reg       <= 1'b0;
        end
        else
        begin
            loaded_count_reg   <= loaded_count_next;
            finished_count_reg <= finished_count_next;
            tick_reg           <= tick_next;
            ptr_reg            <= ptr_next;
            found_reg          <= found_next;
            rd_valid_reg       <= cmd.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= ptr_reg[IDX_W-1:0];
        pick_reg     <= pick_next;
        best_pri_reg <= best_pri_next;
        best_rem_reg <= best_rem_next;
        next_arr_reg <= next_arr_next;
        if (cmd.emit_cap)
        begin
            process_index_reg   <= pps_pkg::PIDX_W'(rd_idx_reg);
            finish_time_reg     <= OUT_W'(fin_rdata);
            turnaround_time_reg <= OUT_W'(tat_full);
            waiting_time_reg    <= OUT_W'(wt_full);
            last_result_reg     <= (CNT_W'(rd_idx_reg) + CNT_W'(1) == loaded_count_reg);
        end
    end

    assign sts.scan_last  = (ptr_reg + CNT_W'(1) == loaded_count_reg);
    assign sts.sched_done = pick_finishes &&
                            (finished_count_reg + CNT_W'(1) == loaded_count_reg);
    assign sts.out_last   = last_result_reg;

    assign process_index   = process_index_reg;
    assign finish_time     = finish_time_reg;
    assign turnaround_time = turnaround_time_reg;
    assign waiting_time    = waiting_time_reg;
    assign last_result     = last_result_reg;

endmodule

// ===== src/pps_controller.sv =====
// Scheduler controller: sequences load, scan, tick update and result emission.
`timescale 1ns / 1ps

module pps_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output pps_pkg::cmd_t cmd,
    input  pps_pkg::sts_t sts
);

    typedef enum logic [6:0] {
        S_LOAD      = 7'b0000001,
        S_SCAN      = 7'b0000010,
        S_SCAN_TAIL = 7'b0000100,
        S_DECIDE    = 7'b0001000,
        S_EMIT_RD   = 7'b0010000,
        S_EMIT_CAP  = 7'b0100000,
        S_EMIT_HOLD = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (in_last)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_SCAN_TAIL;
                end
            end
            S_SCAN_TAIL:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.sched_done ? S_EMIT_RD : S_SCAN;
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_CAP;
            end
            S_EMIT_CAP:
            begin
                cmd.emit_cap = 1'b1;
                state_next   = S_EMIT_HOLD;
            end
            S_EMIT_HOLD:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.out_last)
                    begin
                        cmd.set_clear = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler.
`timescale 1ns / 1ps

// Loads up to MAX_PROCS process descriptions (arrival tick, burst, priority), one per
// input transfer; the transfer with last_process set closes the set and starts the
// run (loads beyond MAX_PROCS are dropped, a zero burst counts as one).
// The run steps through time: on each tick the arrived, unfinished process with the
// largest priority value gets one unit of service, ties going to the lower index, and
// a tick with nothing ready jumps straight to the next arrival. Every tick is a full
// pass over the stored entries through the one read port of each store RAM. Then one
// result per process is sent in load order (finish tick, turnaround, waiting), the
// next one being read only after the last is taken; the input stays stalled from
// the closing transfer until the final result, flagged by last_result, is taken.
// No input is accepted during the run or the result phase.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pps_in_if.sink     in_ch,
    pps_out_if.source  out_ch
);

    pps_pkg::cmd_t cmd;
    pps_pkg::sts_t sts;

    // Sequencing of load, scan, tick update and result transfer
    pps_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_process),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Stores, tick counter, scan compare and result registers
    pps_datapath #(.MAX_PROCS(MAX_PROCS)) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .arrival_time    (in_ch.arrival_time),
        .burst_time      (in_ch.burst_time),
        .priority_req    (in_ch.priority_req),
        .process_index   (out_ch.process_index),
        .finish_time     (out_ch.finish_time),
        .turnaround_time (out_ch.turnaround_time),
        .waiting_time    (out_ch.waiting_time),
        .last_result     (out_ch.last_result)
    );

endmodule
